// ===== design/mme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Request payloads, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package mme_pkg;

    // element width (signed fixed point)
    localparam int ELEM_W = 32;

    // configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] ROWS_A_RST    = 4'd3;
    localparam logic [CFG_W-1:0] INNER_DIM_RST = 4'd3;
    localparam logic [CFG_W-1:0] COLS_B_RST    = 4'd3;

    // operand select codes
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    // input request: one matrix element
    typedef struct packed {
        logic                     operand_select;
        logic signed [ELEM_W-1:0] element_value;
    } t_in_req;

    // output request: one product element
    typedef struct packed {
        logic signed [ELEM_W-1:0] product_element;
        logic                     saturated;
        logic                     last_element;
    } t_out_req;

endpackage

// ===== design/mme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/matrix_multiply_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine: fixed-point matrix product C = A * B
// Loads A and B element by element, then forms every element of C with one
// shared multiply-accumulate unit and streams C out in row-major order.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in       | input     | i_in_valid/o_in_stall| i_in_data  (mme_pkg::t_in_req)
//  out      | output    | o_out_valid/i_out_stall| o_out_data (mme_pkg::t_out_req)
//  cfg      | input     | i_cfg_we             | i_cfg_index, i_cfg_data
//
//  The element that completes B starts the product: each element of C is
//  formed by issuing one store read per inner index through the shared
//  multiplier, draining the read and multiply stages, then the emit step.
//  The output register holds one finished element; a stalled output holds the
//  sequencer at the emit step. No input is taken while the product runs.
//  Reset is synchronous; the operand stores need no clearing pass.
//
module matrix_multiply_engine #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input elements
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mme_pkg::t_in_req                i_in_data,
    // product elements
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mme_pkg::t_out_req               o_out_data,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * mme_pkg::ELEM_W;
    localparam int ACC_W  = PROD_W - FRAC_BITS + $clog2(MAX_DIM) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    // effective dimension: zero reads as one, above MAX_DIM clamps
    function automatic logic [DIM_W-1:0] eff_dim(input logic [mme_pkg::CFG_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return DIM_W'(v);
        end
    endfunction

    logic [mme_pkg::CFG_W-1:0] r_rows_a;
    logic [mme_pkg::CFG_W-1:0] r_inner_dim;
    logic [mme_pkg::CFG_W-1:0] r_cols_b;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_a_cnt;
    logic [CNT_W-1:0]  r_b_cnt;
    logic [DIM_W-1:0]  r_i;
    logic [DIM_W-1:0]  r_j;
    logic [DIM_W-1:0]  r_k;
    logic [ADDR_W-1:0] r_a_row;
    logic [ADDR_W-1:0] r_a_addr;
    logic [ADDR_W-1:0] r_b_addr;
    logic              r_rd_v;
    logic              r_mul_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic              r_out_valid;
    mme_pkg::t_out_req r_out;

    logic [DIM_W-1:0]  w_m;
    logic [DIM_W-1:0]  w_n;
    logic [DIM_W-1:0]  w_p;
    logic [CNT_W-1:0]  w_a_size;
    logic [CNT_W-1:0]  w_b_size;
    logic [CNT_W-1:0]  w_b_cnt_inc;
    logic              w_in_acc;
    logic              w_a_we;
    logic              w_b_we;
    logic              w_b_done;
    logic              w_out_free;
    logic              w_last_col;
    logic              w_last_row;
    logic              w_sat_hi;
    logic              w_sat_lo;
    logic [mme_pkg::ELEM_W-1:0] w_a_rdata;
    logic [mme_pkg::ELEM_W-1:0] w_b_rdata;
    logic signed [PROD_W-1:0]   w_term;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mme_pkg::ROWS_A_RST;
            r_inner_dim <= mme_pkg::INNER_DIM_RST;
            r_cols_b    <= mme_pkg::COLS_B_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mme_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                mme_pkg::CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                mme_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sizes and load decisions
    assign w_m         = eff_dim(r_rows_a);
    assign w_n         = eff_dim(r_inner_dim);
    assign w_p         = eff_dim(r_cols_b);
    assign w_a_size    = CNT_W'(w_m) * CNT_W'(w_n);
    assign w_b_size    = CNT_W'(w_n) * CNT_W'(w_p);
    assign w_b_cnt_inc = r_b_cnt + CNT_W'(1);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_a_we     = w_in_acc && (i_in_data.operand_select == mme_pkg::SEL_A)
                        && (r_a_cnt < w_a_size);
    assign w_b_we     = w_in_acc && (i_in_data.operand_select == mme_pkg::SEL_B)
                        && (32'(r_b_cnt) < DEPTH);
    assign w_b_done   = w_in_acc && (i_in_data.operand_select == mme_pkg::SEL_B)
                        && (w_b_cnt_inc >= w_b_size);

    // operand stores
    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (r_a_cnt[ADDR_W-1:0]),
        .i_wdata (i_in_data.element_value),
        .i_raddr (r_a_addr),
        .o_rdata (w_a_rdata)
    );

    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (r_b_cnt[ADDR_W-1:0]),
        .i_wdata (i_in_data.element_value),
        .i_raddr (r_b_addr),
        .o_rdata (w_b_rdata)
    );

    // load counters; cleared when the product starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_cnt <= '0;
            r_b_cnt <= '0;
        end else if (w_b_done) begin
            r_a_cnt <= '0;
            r_b_cnt <= '0;
        end else begin
            if (w_a_we) begin
                r_a_cnt <= r_a_cnt + CNT_W'(1);
            end
            if (w_in_acc && (i_in_data.operand_select == mme_pkg::SEL_B)) begin
                r_b_cnt <= w_b_cnt_inc;
            end
        end
    end

    // sequencer
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_col = (r_j == w_p - DIM_W'(1));
    assign w_last_row = (r_i == w_m - DIM_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_b_done) n_state = S_ISSUE;
            S_ISSUE: if (r_k == w_n - DIM_W'(1)) n_state = S_DRAIN;
            S_DRAIN: if (!r_rd_v && !r_mul_v) n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = (w_last_col && w_last_row) ? S_IDLE : S_ISSUE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // element indexes and store addresses
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_row  <= '0;
            r_a_addr <= '0;
            r_b_addr <= '0;
        end else if (r_state == S_ISSUE) begin
            r_k      <= r_k + DIM_W'(1);
            r_a_addr <= r_a_addr + ADDR_W'(1);
            r_b_addr <= r_b_addr + ADDR_W'(w_p);
        end else if (r_state == S_EMIT && w_out_free) begin
            r_k <= '0;
            if (w_last_col) begin
                r_i      <= r_i + DIM_W'(1);
                r_j      <= '0;
                r_a_row  <= r_a_row + ADDR_W'(w_n);
                r_a_addr <= r_a_row + ADDR_W'(w_n);
                r_b_addr <= '0;
            end else begin
                r_j      <= r_j + DIM_W'(1);
                r_a_addr <= r_a_row;
                r_b_addr <= ADDR_W'(r_j + DIM_W'(1));
            end
        end
    end

    // multiply-accumulate pipeline: read, multiply, accumulate
    assign w_term = r_prod >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_rd_v  <= (r_state == S_ISSUE);
            r_mul_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_a_rdata) * $signed(w_b_rdata);
        if (r_state == S_IDLE || (r_state == S_EMIT && w_out_free)) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + ACC_W'(w_term);
        end
    end

    // clamp to the signed 32-bit range
    assign w_sat_hi = !r_acc[ACC_W-1] && (r_acc[ACC_W-2:mme_pkg::ELEM_W-1] != '0);
    assign w_sat_lo = r_acc[ACC_W-1] && (r_acc[ACC_W-2:mme_pkg::ELEM_W-1] != '1);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            if (w_sat_hi) begin
                r_out.product_element <= {1'b0, {(mme_pkg::ELEM_W-1){1'b1}}};
            end else if (w_sat_lo) begin
                r_out.product_element <= {1'b1, {(mme_pkg::ELEM_W-1){1'b0}}};
            end else begin
                r_out.product_element <= r_acc[mme_pkg::ELEM_W-1:0];
            end
            r_out.saturated    <= w_sat_hi || w_sat_lo;
            r_out.last_element <= w_last_col && w_last_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // no element is loaded while the product runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_a_cnt == '0 && r_b_cnt == '0))
        else $error("load counters not clear during product");

    // the pipeline has drained before a sum is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!r_rd_v && !r_mul_v))
        else $error("sum emitted with terms still in flight");

    // inner index stays within the inner dimension
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_k < w_n))
        else $error("inner index out of range");

    // a product start always enters the issue step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_done |=> (r_state == S_ISSUE))
        else $error("product did not start");

endmodule

// ===== sim/matrix_multiply_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_tb: self-checking bench for the matrix product engine
// Streams A and B elements into the block, predicts every element of A * B in
// Q16.16 with its own copy of the operand stores, and compares each product
// request field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_tb;

    localparam int MAX_DIM        = 8;
    localparam int FRAC_BITS      = 16;
    localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ITEM_TARGET    = 380;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_PHASE     = 3;
    localparam int QUIET_LIMIT    = 3000;
    localparam int NUM_FIXED_DIMS = 6;

    localparam longint SUM_MAX = (64'sd1 <<< 31) - 1;
    localparam longint SUM_MIN = -(64'sd1 <<< 31);

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;
    typedef enum int {SEQ_FULL, SEQ_MIXED, SEQ_NOISE, SEQ_BROKEN} t_seq_kind;

    // clock, reset and block inputs
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    mme_pkg::t_in_req              in_data   = '0;
    logic                          out_stall = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [mme_pkg::CFG_IDX_W-1:0] cfg_index = mme_pkg::CFG_ROWS_A;
    logic [mme_pkg::CFG_W-1:0]     cfg_data  = '0;

    logic                          in_stall;
    logic                          out_valid;
    mme_pkg::t_out_req             out_data;

    // dimension registers as last written
    logic [mme_pkg::CFG_W-1:0] dim_regs [3] = '{mme_pkg::ROWS_A_RST,
                                                mme_pkg::INNER_DIM_RST,
                                                mme_pkg::COLS_B_RST};

    // predicted operand stores and load counts
    logic signed [mme_pkg::ELEM_W-1:0] a_store [STORE_DEPTH] = '{default: '0};
    logic signed [mme_pkg::ELEM_W-1:0] b_store [STORE_DEPTH] = '{default: '0};
    int a_fill = 0;
    int b_fill = 0;

    // stimulus planning: load counts and the written prefix of A
    int plan_a_fill   = 0;
    int plan_b_fill   = 0;
    int plan_a_high   = 0;
    int plan_products = 0;
    int n_useful      = 0;

    mme_pkg::t_in_req  element_queue [$];
    mme_pkg::t_out_req product_expect [$];

    int fail_count  = 0;
    int quiet_count = 0;

    // sender bursts and gaps
    int burst_left = 8;
    int gap_left   = 0;

    // receiver stall pattern and the one long hold-off
    t_stall_mode stall_mode = STALL_NONE;
    int          seg_left   = 0;
    logic        long_hold  = 1'b0;
    logic        hold_done  = 1'b0;
    int          hold_count = 0;

    logic [mme_pkg::CFG_W-1:0] fixed_dims [NUM_FIXED_DIMS][3] = '{
        '{4'd15, 4'd15, 4'd15},
        '{4'd8,  4'd1,  4'd8},
        '{4'd1,  4'd8,  4'd1},
        '{4'd2,  4'd3,  4'd2},
        '{4'd0,  4'd15, 4'd0},
        '{4'd3,  4'd3,  4'd3}
    };

    matrix_multiply_engine #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register value to dimension: zero acts as 1, large values clamp
    function automatic int dim_eff(logic [mme_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // load one element; on the element that completes B, predict all of A * B
    function automatic void absorb_element(mme_pkg::t_in_req req);
        int                m, n, p, i, j, k;
        longint            acc;
        mme_pkg::t_out_req res;
        m = dim_eff(dim_regs[mme_pkg::CFG_ROWS_A]);
        n = dim_eff(dim_regs[mme_pkg::CFG_INNER_DIM]);
        p = dim_eff(dim_regs[mme_pkg::CFG_COLS_B]);
        if (req.operand_select == mme_pkg::SEL_A) begin
            if (a_fill < m * n) begin
                a_store[a_fill] = req.element_value;
                a_fill++;
            end
        end else begin
            if (b_fill < STORE_DEPTH) b_store[b_fill] = req.element_value;
            b_fill++;
            if (b_fill >= n * p) begin
                for (i = 0; i < m; i++) begin
                    for (j = 0; j < p; j++) begin
                        acc = 0;
                        // products floor to Q16.16, the sum is exact until the clamp
                        for (k = 0; k < n; k++)
                            acc += (longint'(a_store[i * n + k]) *
                                    longint'(b_store[k * p + j])) >>> FRAC_BITS;
                        res.saturated = 1'b0;
                        if (acc > SUM_MAX) begin
                            acc = SUM_MAX;
                            res.saturated = 1'b1;
                        end else if (acc < SUM_MIN) begin
                            acc = SUM_MIN;
                            res.saturated = 1'b1;
                        end
                        res.product_element = acc[mme_pkg::ELEM_W-1:0];
                        res.last_element = (i == m - 1) && (j == p - 1);
                        product_expect.push_back(res);
                    end
                end
                a_fill = 0;
                b_fill = 0;
            end
        end
    endfunction

    // queue one element; a B that would start a product reading unwritten A
    // entries is turned into an A element
    function automatic void queue_element(logic sel,
                                          logic signed [mme_pkg::ELEM_W-1:0] val);
        int               m, n, p;
        mme_pkg::t_in_req req;
        m = dim_eff(dim_regs[mme_pkg::CFG_ROWS_A]);
        n = dim_eff(dim_regs[mme_pkg::CFG_INNER_DIM]);
        p = dim_eff(dim_regs[mme_pkg::CFG_COLS_B]);
        if (sel == mme_pkg::SEL_B && plan_b_fill + 1 >= n * p && plan_a_high < m * n)
            sel = mme_pkg::SEL_A;
        req.operand_select = sel;
        req.element_value  = val;
        element_queue.push_back(req);
        if (sel == mme_pkg::SEL_A) begin
            if (plan_a_fill < m * n) begin
                plan_a_fill++;
                if (plan_a_fill > plan_a_high) plan_a_high = plan_a_fill;
                n_useful++;
            end
        end else begin
            plan_b_fill++;
            n_useful++;
            if (plan_b_fill >= n * p) begin
                plan_a_fill = 0;
                plan_b_fill = 0;
                plan_products++;
            end
        end
    endfunction

    // mix of full-range, extreme and small Q16.16 values
    function automatic logic signed [mme_pkg::ELEM_W-1:0] rand_elem();
        logic signed [mme_pkg::ELEM_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sh0000_0000;
                    default: v = 32'shFFFF_FFFF;
                endcase
            end
            default: begin
                v = $urandom_range(0, 20'hF_FFFF);
                v = v - 32'sh0008_0000;
            end
        endcase
        return v;
    endfunction

    task automatic write_reg(logic [mme_pkg::CFG_IDX_W-1:0] idx,
                             logic [mme_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        dim_regs[idx] = val;
    endtask

    task automatic set_dims(logic [mme_pkg::CFG_W-1:0] rows,
                            logic [mme_pkg::CFG_W-1:0] inner,
                            logic [mme_pkg::CFG_W-1:0] cols);
        write_reg(mme_pkg::CFG_ROWS_A, rows);
        write_reg(mme_pkg::CFG_INNER_DIM, inner);
        write_reg(mme_pkg::CFG_COLS_B, cols);
    endtask

    // block idle: every element taken, every product element seen
    task automatic wait_drained();
        while (element_queue.size() != 0 || in_valid || product_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver: bursts of requests from the element queue with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) absorb_element(in_data);
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (element_queue.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= element_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: random segments of different stall densities
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (long_hold && !hold_done) begin
            if (hold_count == HOLD_CYCLES) begin
                hold_done <= 1'b1;
                out_stall <= 1'b0;
            end else begin
                hold_count <= hold_count + 1;
                out_stall  <= 1'b1;
            end
        end else if (seg_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            seg_left   <= $urandom_range(10, 150);
            out_stall  <= 1'b0;
        end else begin
            seg_left <= seg_left - 1;
            case (stall_mode)
                STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: out_stall <= !out_stall;
                default:      out_stall <= 1'b0;
            endcase
        end
    end

    // monitor: compare each product request with the oldest prediction
    always @(posedge clk) begin
        mme_pkg::t_out_req want;
        if (rst_n && out_valid && !out_stall) begin
            if (product_expect.size() == 0) begin
                $error("unexpected product element %0d", out_data.product_element);
                fail_count++;
            end else begin
                want = product_expect.pop_front();
                if (out_data.product_element !== want.product_element) begin
                    $error("product_element: expected %0d, got %0d",
                           want.product_element, out_data.product_element);
                    fail_count++;
                end
                if (out_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, out_data.saturated);
                    fail_count++;
                end
                if (out_data.last_element !== want.last_element) begin
                    $error("last_element: expected %0b, got %0b",
                           want.last_element, out_data.last_element);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_count <= 0;
        end else if (quiet_count == QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // stimulus
    initial begin
        int                        m, n, p, s, nseq, cnt, start, phase;
        t_seq_kind                 kind;
        logic [mme_pkg::CFG_W-1:0] dims [3];

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // 1x1x1 products (registers at zero): saturation both ways, floor rounding
        set_dims(4'd0, 4'd0, 4'd0);
        queue_element(mme_pkg::SEL_A, 32'sh7FFF_FFFF);
        queue_element(mme_pkg::SEL_B, 32'sh7FFF_FFFF);
        queue_element(mme_pkg::SEL_A, 32'sh8000_0000);
        queue_element(mme_pkg::SEL_B, 32'sh7FFF_FFFF);
        queue_element(mme_pkg::SEL_A, 32'sh8000_0000);
        queue_element(mme_pkg::SEL_B, 32'sh8000_0000);
        queue_element(mme_pkg::SEL_A, 32'sh0001_0000);
        queue_element(mme_pkg::SEL_B, 32'shFFFF_FFFF);
        queue_element(mme_pkg::SEL_A, 32'shFFFF_FFFF);
        queue_element(mme_pkg::SEL_B, 32'shFFFF_FFFF);
        queue_element(mme_pkg::SEL_A, 32'sh0000_0000);
        queue_element(mme_pkg::SEL_B, 32'sh0000_0000);
        // extra A is dropped
        queue_element(mme_pkg::SEL_A, 32'sh0005_0000);
        queue_element(mme_pkg::SEL_A, 32'sh0007_0000);
        queue_element(mme_pkg::SEL_B, 32'sh0002_0000);
        // B alone reuses the A left from the last product
        queue_element(mme_pkg::SEL_B, 32'shFFFF_0000);
        wait_drained();

        // 2x2x2 partly loaded, then B shrinks so the next B starts the product
        set_dims(4'd2, 4'd2, 4'd2);
        queue_element(mme_pkg::SEL_A, 32'sh0001_0000);
        queue_element(mme_pkg::SEL_A, 32'sh0002_0000);
        queue_element(mme_pkg::SEL_A, 32'sh0003_0000);
        queue_element(mme_pkg::SEL_A, 32'sh0004_0000);
        queue_element(mme_pkg::SEL_B, 32'sh0001_0000);
        queue_element(mme_pkg::SEL_B, 32'sh0002_0000);
        wait_drained();
        write_reg(mme_pkg::CFG_COLS_B, 4'd1);
        queue_element(mme_pkg::SEL_B, 32'sh0003_0000);

        // random phases, each with its own dimensions
        phase = 0;
        while (n_useful < ITEM_TARGET) begin
            wait_drained();
            for (int d = 0; d < 3; d++) begin
                if (phase < NUM_FIXED_DIMS)
                    dims[d] = fixed_dims[phase][d];
                else if ($urandom_range(0, 7) == 0)
                    dims[d] = mme_pkg::CFG_W'($urandom_range(0, 15));
                else
                    dims[d] = mme_pkg::CFG_W'($urandom_range(1, 4));
            end
            set_dims(dims[0], dims[1], dims[2]);
            m = dim_eff(dims[0]);
            n = dim_eff(dims[1]);
            p = dim_eff(dims[2]);
            if (phase == HOLD_PHASE) long_hold <= 1'b1;
            nseq = (m * n + n * p > 40) ? 1 : $urandom_range(2, 5);
            for (s = 0; s < nseq; s++) begin
                cnt = $urandom_range(0, 9);
                kind = (cnt < 6) ? SEQ_FULL : (cnt < 8) ? SEQ_MIXED :
                       (cnt == 8) ? SEQ_NOISE : SEQ_BROKEN;
                case (kind)
                    SEQ_FULL: begin
                        for (cnt = 0; cnt < m * n; cnt++)
                            queue_element(mme_pkg::SEL_A, rand_elem());
                        for (cnt = 0; cnt < n * p; cnt++)
                            queue_element(mme_pkg::SEL_B, rand_elem());
                    end
                    SEQ_MIXED: begin
                        start = plan_products;
                        while (plan_products == start)
                            queue_element($urandom_range(0, 1) ? mme_pkg::SEL_B
                                                               : mme_pkg::SEL_A,
                                          rand_elem());
                    end
                    SEQ_NOISE: begin
                        for (cnt = $urandom_range(1, 6); cnt > 0; cnt--)
                            queue_element($urandom_range(0, 1) ? mme_pkg::SEL_B
                                                               : mme_pkg::SEL_A,
                                          rand_elem());
                    end
                    default: begin
                        for (cnt = $urandom_range(0, m * n + 2); cnt > 0; cnt--)
                            queue_element(mme_pkg::SEL_A, rand_elem());
                        for (cnt = $urandom_range(0, n * p - 1); cnt > 0; cnt--)
                            queue_element(mme_pkg::SEL_B, rand_elem());
                    end
                endcase
            end
            phase++;
        end
        wait_drained();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
